// ----- hw/rtl/assert_macros.svh -----
// Assertion macros, all clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) `ASSERT_CLK(label, (ante) |-> (cons), msg)

`define ASSERT_NEXT(label, ante, cons, msg) `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/hvn_pkg.sv -----
package hvn_pkg;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_RECIP = 2'd2;

  localparam logic [10:0] GRID_WIDTH_RST  = 11'd257;
  localparam logic [15:0] GRID_HEIGHT_RST = 16'd257;
  localparam logic [23:0] RECIP_RST       = 24'd65536;

  localparam int unsigned IX = 0;
  localparam int unsigned IY = 1;
  localparam int unsigned IZ = 2;

  typedef struct packed {
    logic last_col;
    logic last_row;
  } cmd_flags_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic        [15:0] y;
    logic signed [15:0] z;
  } face_t;

  typedef logic [2:0][30:0] vin_t;
  typedef logic [2:0][17:0] vq_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

  typedef struct packed {
    logic        [9:0]  col;
    logic        [15:0] row;
    logic signed [15:0] nx;
    logic        [14:0] ny;
    logic signed [15:0] nz;
    logic               last_of_run;
    logic               grid_done;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_NORM,
    N_SQRT,
    N_PREP,
    N_DIV
  } norm_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WAIT,
    B_FACE,
    B_FACE_WAIT,
    B_VSTART,
    B_VWAIT,
    B_PUSH
  } back_state_e;

  typedef enum logic [1:0] {
    JOB_UL,
    JOB_UR,
    JOB_LL,
    JOB_LR
  } job_e;

  function automatic logic signed [15:0] clip15(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hvn_fifo.sv -----
`include "assert_macros.svh"

module hvn_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNTW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEXT(a_push_fills, push_i && !full_o, !empty_o, "fifo empty after push")
  `ASSERT_NEXT(a_pop_frees, pop_i && !empty_o && !push_i, !full_o, "fifo full after pop")

endmodule

// ----- hw/rtl/hvn_front.sv -----
module hvn_front #(
  parameter int unsigned MAX_GRID_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_GRID_WIDTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [15:0]         height_sample_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output logic [31:0]         cmd_height_o,
  output logic [CW-1:0]       cmd_col_o,
  output logic [15:0]         cmd_row_o,
  output hvn_pkg::cmd_flags_t cmd_flags_o
);

  import hvn_pkg::*;

  localparam int unsigned EW = (CW + 1 > 11) ? CW + 1 : 11;

  front_state_e  state_q, state_d;
  logic [10:0]   gw_q;
  logic [15:0]   gh_q;
  logic [23:0]   recip_q;
  logic [15:0]   samp_q;
  logic [39:0]   prod_q;
  logic [CW-1:0] col_q, c_eff;
  logic [15:0]   row_q, ht_cl;
  logic [EW-1:0] w_raw, w_cl;
  logic          accept, last_col, last_row, advance;

  assign full    = state_q != F_IDLE;
  assign accept  = push && !full;
  assign advance = (state_q == F_PUSH) && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = F_PUSH;
      F_PUSH: if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= GRID_WIDTH_RST;
      gh_q    <= GRID_HEIGHT_RST;
      recip_q <= RECIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:   gw_q    <= cfg_data_i[10:0];
        CFG_GRID_HEIGHT:  gh_q    <= cfg_data_i[15:0];
        CFG_HEIGHT_RECIP: recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= height_sample_i;
    end
    if (state_q == F_MUL) begin
      prod_q <= 40'(samp_q) * 40'(recip_q);
    end
  end

  assign w_raw = EW'(gw_q);

  always_comb begin
    if (w_raw < EW'(2)) begin
      w_cl = EW'(2);
    end else if (w_raw > EW'(MAX_GRID_WIDTH)) begin
      w_cl = EW'(MAX_GRID_WIDTH);
    end else begin
      w_cl = w_raw;
    end
    if (EW'(col_q) >= EW'(MAX_GRID_WIDTH)) begin
      c_eff = CW'(MAX_GRID_WIDTH - 1);
    end else begin
      c_eff = col_q;
    end
    ht_cl    = (gh_q < 16'd2) ? 16'd2 : gh_q;
    last_col = EW'(c_eff) >= w_cl - EW'(1);
    last_row = row_q >= ht_cl - 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 16'd1;
      end else begin
        col_q <= c_eff + CW'(1);
      end
    end
  end

  assign cmd_valid_o          = state_q == F_PUSH;
  assign cmd_height_o         = 32'((41'(prod_q) + 41'd128) >> 8);
  assign cmd_col_o            = c_eff;
  assign cmd_row_o            = row_q;
  assign cmd_flags_o.last_col = last_col;
  assign cmd_flags_o.last_row = last_row;

endmodule

// ----- hw/rtl/hvn_norm.sv -----
`include "assert_macros.svh"

module hvn_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hvn_pkg::vin_t       vec_i,
  output hvn_pkg::norm_stat_t stat_o,
  output hvn_pkg::vq_t        q_o
);

  import hvn_pkg::*;

  norm_state_e  state_q, state_d;
  logic [29:0]  m_q [3];
  logic [2:0]   neg_q;
  logic [63:0]  s_q, x_q, r_q, bit_q, t;
  logic [4:0]   h_q, cnt_q;
  logic [1:0]   idx_q;
  logic [59:0]  sq;
  logic [48:0]  rem_q [3];
  logic [47:0]  d_q;
  logic [16:0]  q_q [3];
  logic [31:0]  len;
  logic [5:0]   sh;
  logic         done_q, zero_q;

  assign sq  = 60'(m_q[idx_q]) * 60'(m_q[idx_q]);
  assign t   = r_q + bit_q;
  assign len = r_q[31:0];
  assign sh  = 6'd15 + 6'(h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE: if (start_i) state_d = N_SQ;
      N_SQ:   if (idx_q == 2'd2) state_d = N_NORM;
      N_NORM: begin
        if (s_q == '0) begin
          state_d = N_IDLE;
        end else if (s_q[63:62] != 2'b00) begin
          state_d = N_SQRT;
        end
      end
      N_SQRT: if (bit_q[0]) state_d = N_PREP;
      N_PREP: state_d = N_DIV;
      N_DIV:  if (cnt_q == '0) state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (state_q == N_NORM && s_q == '0) begin
        done_q <= 1'b1;
        zero_q <= 1'b1;
      end else if (state_q == N_DIV && cnt_q == '0) begin
        done_q <= 1'b1;
        zero_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][30];
            m_q[i]   <= vec_i[i][30] ? 30'(-vec_i[i]) : vec_i[i][29:0];
          end
          s_q   <= '0;
          h_q   <= '0;
          idx_q <= '0;
        end
      end
      N_SQ: begin
        s_q   <= s_q + 64'(sq);
        idx_q <= idx_q + 2'd1;
      end
      N_NORM: begin
        if (s_q[63:56] == 8'd0) begin
          s_q <= s_q << 8;
          h_q <= h_q + 5'd4;
        end else if (s_q[63:62] == 2'b00) begin
          s_q <= s_q << 2;
          h_q <= h_q + 5'd1;
        end else begin
          x_q   <= s_q;
          r_q   <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
        end
      end
      N_SQRT: begin
        if (x_q >= t) begin
          x_q <= x_q - t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_PREP: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= (49'(m_q[i]) << sh) + 49'(len[31:1]);
          q_q[i]   <= '0;
        end
        d_q   <= {len, 16'd0};
        cnt_q <= 5'd16;
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= 49'(d_q)) begin
            rem_q[i] <= rem_q[i] - 49'(d_q);
            q_q[i]   <= {q_q[i][15:0], 1'b1};
          end else begin
            q_q[i]   <= {q_q[i][15:0], 1'b0};
          end
        end
        d_q   <= d_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_o[i] = neg_q[i] ? -{1'b0, q_q[i]} : {1'b0, q_q[i]};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = zero_q;

  `ASSERT_IMPLIES(a_start_idle, start_i, state_q == N_IDLE, "normalizer started while busy")

endmodule

// ----- hw/rtl/hvn_back.sv -----
`include "assert_macros.svh"

module hvn_back #(
  parameter int unsigned MAX_GRID_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_GRID_WIDTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  logic [31:0]         cmd_height_i,
  input  logic [CW-1:0]       cmd_col_i,
  input  logic [15:0]         cmd_row_i,
  input  hvn_pkg::cmd_flags_t cmd_flags_i,
  input  logic                res_full_i,
  output logic                res_push_o,
  output hvn_pkg::res_t       res_o
);

  import hvn_pkg::*;

  back_state_e   state_q, state_d;
  logic [31:0]   hgt_mem [MAX_GRID_WIDTH];
  face_t         face_mem [MAX_GRID_WIDTH];
  logic [31:0]   up_q, left_h_q, ul_h_q;
  face_t         fu_rd_q, f_q, left_f_q, ul_f_q;
  vin_t          fvec_q, sum_vec, norm_vec, fvec;
  job_e          job_q, next_job;
  res_t          res_q;
  norm_stat_t    norm_stat;
  vq_t           norm_q;
  logic [CW-1:0] col_m1;
  logic          has_face, col_ge2, row_ge2, next_ok, norm_start, rd_en, fin;
  logic signed [32:0] da, dc;
  logic [31:0]   ma, mc, orv, sa, sc;
  logic [1:0]    k;
  logic signed [19:0] sx, sy, sz;
  logic signed [18:0] yv;
  logic          use_left, use_up, use_ul;

  hvn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .stat_o  (norm_stat),
    .q_o     (norm_q)
  );

  assign has_face = (cmd_row_i != 16'd0) && (cmd_col_i != '0);
  assign col_ge2  = {1'b0, cmd_col_i} >= (CW + 1)'(2);
  assign row_ge2  = cmd_row_i >= 16'd2;
  assign col_m1   = cmd_col_i - CW'(1);

  always_comb begin
    next_ok  = 1'b0;
    next_job = job_q;
    unique case (job_q)
      JOB_UL: begin
        if (cmd_flags_i.last_col) begin
          next_ok  = 1'b1;
          next_job = JOB_UR;
        end else if (cmd_flags_i.last_row) begin
          next_ok  = 1'b1;
          next_job = JOB_LL;
        end
      end
      JOB_UR: begin
        if (cmd_flags_i.last_row) begin
          next_ok  = 1'b1;
          next_job = JOB_LL;
        end
      end
      JOB_LL: begin
        if (cmd_flags_i.last_col) begin
          next_ok  = 1'b1;
          next_job = JOB_LR;
        end
      end
      JOB_LR: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    norm_start = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    rd_en      = 1'b0;
    fin        = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          rd_en   = 1'b1;
          state_d = B_WAIT;
        end
      end
      B_WAIT: begin
        if (has_face) begin
          state_d = B_FACE;
        end else begin
          cmd_pop_o = 1'b1;
          state_d   = B_IDLE;
        end
      end
      B_FACE: begin
        norm_start = 1'b1;
        state_d    = B_FACE_WAIT;
      end
      B_FACE_WAIT: if (norm_stat.done) state_d = B_VSTART;
      B_VSTART: begin
        norm_start = 1'b1;
        state_d    = B_VWAIT;
      end
      B_VWAIT: if (norm_stat.done) state_d = B_PUSH;
      B_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (next_ok) begin
            state_d = B_VSTART;
          end else begin
            fin       = 1'b1;
            cmd_pop_o = 1'b1;
            state_d   = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      up_q                <= hgt_mem[cmd_col_i];
      fu_rd_q             <= face_mem[col_m1];
      hgt_mem[cmd_col_i]  <= cmd_height_i;
    end
    if (fin) begin
      face_mem[col_m1] <= f_q;
    end
  end

  always_comb begin
    da  = $signed({1'b0, left_h_q}) - $signed({1'b0, cmd_height_i});
    dc  = $signed({1'b0, left_h_q}) - $signed({1'b0, ul_h_q});
    ma  = da[32] ? 32'(-da) : da[31:0];
    mc  = dc[32] ? 32'(-dc) : dc[31:0];
    orv = ma | mc;
    if (orv[31]) begin
      k = 2'd2;
    end else if (orv[30]) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    sa = ma >> k;
    sc = mc >> k;
    fvec[IX] = da[32] ? -31'(sa) : 31'(sa);
    fvec[IY] = 31'(9'd256 >> k);
    fvec[IZ] = dc[32] ? -31'(sc) : 31'(sc);
  end

  always_comb begin
    use_left = ((job_q == JOB_UL) || (job_q == JOB_LL)) && col_ge2;
    use_up   = ((job_q == JOB_UL) || (job_q == JOB_UR)) && row_ge2;
    use_ul   = (job_q == JOB_UL) && row_ge2 && col_ge2;
    sx = 20'(f_q.x);
    sy = $signed({4'b0000, f_q.y});
    sz = 20'(f_q.z);
    if (use_left) begin
      sx = sx + 20'(left_f_q.x);
      sy = sy + $signed({4'b0000, left_f_q.y});
      sz = sz + 20'(left_f_q.z);
    end
    if (use_up) begin
      sx = sx + 20'(fu_rd_q.x);
      sy = sy + $signed({4'b0000, fu_rd_q.y});
      sz = sz + 20'(fu_rd_q.z);
    end
    if (use_ul) begin
      sx = sx + 20'(ul_f_q.x);
      sy = sy + $signed({4'b0000, ul_f_q.y});
      sz = sz + 20'(ul_f_q.z);
    end
    sum_vec[IX] = 31'(sx);
    sum_vec[IY] = 31'(sy);
    sum_vec[IZ] = 31'(sz);
    norm_vec    = (state_q == B_FACE) ? fvec_q : sum_vec;
    yv          = 19'($signed(norm_q[IY]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_h_q <= '0;
      ul_h_q   <= '0;
      left_f_q <= '0;
      ul_f_q   <= '0;
    end else begin
      if (state_q == B_WAIT) begin
        left_h_q <= cmd_height_i;
        ul_h_q   <= up_q;
      end
      if (fin) begin
        left_f_q <= f_q;
        ul_f_q   <= fu_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_WAIT) begin
      fvec_q <= fvec;
    end
    if (state_q == B_FACE_WAIT && norm_stat.done) begin
      f_q.x <= clip15($signed(norm_q[IX]));
      f_q.y <= norm_q[IY][15:0];
      f_q.z <= clip15($signed(norm_q[IZ]));
      job_q <= JOB_UL;
    end
    if (state_q == B_PUSH && !res_full_i && next_ok) begin
      job_q <= next_job;
    end
    if (state_q == B_VWAIT && norm_stat.done) begin
      res_q.col <= ((job_q == JOB_UR) || (job_q == JOB_LR)) ? 10'(cmd_col_i) : 10'(col_m1);
      res_q.row <= ((job_q == JOB_LL) || (job_q == JOB_LR)) ? cmd_row_i
                                                             : cmd_row_i - 16'd1;
      if (norm_stat.zero) begin
        res_q.nx <= '0;
        res_q.ny <= 15'd32767;
        res_q.nz <= '0;
      end else begin
        res_q.nx <= clip15($signed(norm_q[IX]));
        res_q.nz <= clip15($signed(norm_q[IZ]));
        if (yv < 19'sd0) begin
          res_q.ny <= '0;
        end else if (yv > 19'sd32767) begin
          res_q.ny <= 15'd32767;
        end else begin
          res_q.ny <= 15'(yv);
        end
      end
      res_q.last_of_run <= !next_ok;
      res_q.grid_done   <= job_q == JOB_LR;
    end
  end

  assign res_o = res_q;

  `ASSERT_IMPLIES(a_start_with_cmd, norm_start, cmd_valid_i, "normalizer run without a command")

endmodule

// ----- hw/rtl/heightmap_vertex_normals.sv -----
// Each sample that closes a face yields one or more vertex normals, computed in turn by
// the shared normalizer (three squares, a 32-step square root, a 17-step divider), after
// the face normal itself; samples with no face produce no normal. A two-entry command
// queue lets new samples be accepted while the normalizer is busy, until the queue fills.
// Reset (rst_ni low, asynchronous): control, counters and configuration registers return to defaults;
// the line buffers are not cleared and need no clearing pass.
module heightmap_vertex_normals #(
  parameter int unsigned MAX_GRID_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        height_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         vertex_col_o,
  output logic [15:0]        vertex_row_o,
  output logic signed [15:0] normal_x_o,
  output logic [14:0]        normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               last_of_run_o,
  output logic               grid_done_o
);

  import hvn_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_GRID_WIDTH);
  localparam int unsigned CMDW = 32 + CW + 16 + $bits(cmd_flags_t);

  logic            f_valid, q_full, q_empty, b_pop, r_full, b_push;
  logic [31:0]     f_height, b_height;
  logic [CW-1:0]   f_col, b_col;
  logic [15:0]     f_row, b_row;
  cmd_flags_t      f_flags, b_flags;
  logic [CMDW-1:0] q_in, q_out;
  res_t            b_res, r_out;

  hvn_front #(.MAX_GRID_WIDTH(MAX_GRID_WIDTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .height_sample_i (height_sample_i),
    .cmd_valid_o     (f_valid),
    .cmd_ready_i     (!q_full),
    .cmd_height_o    (f_height),
    .cmd_col_o       (f_col),
    .cmd_row_o       (f_row),
    .cmd_flags_o     (f_flags)
  );

  assign q_in = {f_height, f_col, f_row, f_flags};

  hvn_fifo #(.WIDTH(CMDW), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign {b_height, b_col, b_row, b_flags} = q_out;

  hvn_back #(.MAX_GRID_WIDTH(MAX_GRID_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!q_empty),
    .cmd_pop_o    (b_pop),
    .cmd_height_i (b_height),
    .cmd_col_i    (b_col),
    .cmd_row_i    (b_row),
    .cmd_flags_i  (b_flags),
    .res_full_i   (r_full),
    .res_push_o   (b_push),
    .res_o        (b_res)
  );

  hvn_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_push),
    .data_i  (b_res),
    .full_o  (r_full),
    .pop_i   (pop),
    .data_o  (r_out),
    .empty_o (empty)
  );

  assign vertex_col_o  = r_out.col;
  assign vertex_row_o  = r_out.row;
  assign normal_x_o    = r_out.nx;
  assign normal_y_o    = r_out.ny;
  assign normal_z_o    = r_out.nz;
  assign last_of_run_o = r_out.last_of_run;
  assign grid_done_o   = r_out.grid_done;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hvn_pkg::*;

  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int unsigned MAX_W = 1024;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 500;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef enum int {
    SMP_RANDOM,
    SMP_SMOOTH,
    SMP_FLAT,
    SMP_CHECKER,
    SMP_RAMP
  } sample_mode_e;

  class normal_scoreboard;
    res_t expected_q[$];
    int errors;
    longint unsigned width_reg, height_reg, recip_reg;
    longint row_heights[MAX_W];
    vec_t row_faces[MAX_W];
    longint left_h, upleft_h;
    vec_t left_f, upleft_f;
    int unsigned col_cnt, row_cnt;

    function new();
      width_reg = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      recip_reg = RECIP_RST;
      left_h = 0;
      upleft_h = 0;
      left_f = '{0, 0, 0};
      upleft_f = '{0, 0, 0};
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      foreach (row_heights[i]) begin
        row_heights[i] = 0;
        row_faces[i] = '{0, 0, 0};
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == CFG_GRID_WIDTH) width_reg = val & 24'h7FF;
      else if (idx == CFG_GRID_HEIGHT) height_reg = val & 24'hFFFF;
      else if (idx == CFG_HEIGHT_RECIP) recip_reg = val;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit to_unit(vec_t v, output vec_t q);
      longint vv[3];
      longint rr[3];
      longint unsigned m[3];
      longint unsigned s, len, qq;
      int unsigned sh;
      vv = '{v.x, v.y, v.z};
      s = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = vv[i] < 0 ? -vv[i] : vv[i];
        s += m[i] * m[i];
      end
      q = '{0, 0, 0};
      if (s == 0) return 0;
      while (s < 64'h4000_0000_0000_0000) begin
        s <<= 2;
        sh++;
      end
      len = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        qq = ((m[i] << (15 + sh)) + (len >> 1)) / len;
        rr[i] = vv[i] < 0 ? -longint'(qq) : longint'(qq);
      end
      q = '{rr[0], rr[1], rr[2]};
      return 1;
    endfunction

    function longint clip(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
    endfunction

    function vec_t face(longint h1, longint h2, longint h3);
      longint a, c;
      longint unsigned ma, mc;
      int unsigned k;
      vec_t v, q, f;
      a = h1 - h2;
      c = h1 - h3;
      ma = a < 0 ? -a : a;
      mc = c < 0 ? -c : c;
      k = 0;
      while (((ma >> k) | (mc >> k)) >= 64'h4000_0000) k++;
      v.x = a < 0 ? -longint'(ma >> k) : longint'(ma >> k);
      v.y = 256 >> k;
      v.z = c < 0 ? -longint'(mc >> k) : longint'(mc >> k);
      void'(to_unit(v, q));
      f.x = clip(q.x);
      f.y = q.y;
      f.z = clip(q.z);
      return f;
    endfunction

    function vec_t add(vec_t a, vec_t b);
      return '{a.x + b.x, a.y + b.y, a.z + b.z};
    endfunction

    function void emit(int unsigned col, int unsigned row, vec_t s);
      vec_t q;
      res_t r;
      longint ny;
      if (!to_unit(s, q)) q = '{0, 32767, 0};
      ny = q.y > 32767 ? 32767 : (q.y < 0 ? 0 : q.y);
      r.col = col[9:0];
      r.row = row[15:0];
      r.nx = 16'(clip(q.x));
      r.ny = 15'(ny);
      r.nz = 16'(clip(q.z));
      r.last_of_run = 1'b0;
      r.grid_done = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_sample(logic [15:0] smp);
      int unsigned w, ht, c, r, n0;
      bit lastc, lastr;
      longint h, up;
      vec_t f, fu, s;
      res_t t;
      w = width_reg < 2 ? 2 : (width_reg > MAX_W ? MAX_W : width_reg);
      ht = height_reg < 2 ? 2 : height_reg;
      c = col_cnt >= MAX_W ? MAX_W - 1 : col_cnt;
      r = row_cnt;
      lastc = c >= w - 1;
      lastr = r >= ht - 1;
      h = (longint'(smp) * longint'(recip_reg) + 128) >>> 8;
      up = row_heights[c];
      n0 = expected_q.size();
      if (r >= 1 && c >= 1) begin
        f = face(left_h, h, upleft_h);
        fu = row_faces[c - 1];
        s = f;
        if (c >= 2) s = add(s, left_f);
        if (r >= 2) begin
          s = add(s, fu);
          if (c >= 2) s = add(s, upleft_f);
        end
        emit(c - 1, r - 1, s);
        if (lastc) begin
          s = f;
          if (r >= 2) s = add(s, fu);
          emit(c, r - 1, s);
        end
        if (lastr) begin
          s = f;
          if (c >= 2) s = add(s, left_f);
          emit(c - 1, r, s);
          if (lastc) emit(c, r, f);
        end
        row_faces[c - 1] = f;
        upleft_f = fu;
        left_f = f;
      end
      row_heights[c] = h;
      left_h = h;
      upleft_h = up;
      if (expected_q.size() > n0) begin
        t = expected_q.pop_back();
        t.last_of_run = 1'b1;
        t.grid_done = lastc && lastr;
        expected_q.push_back(t);
      end
      if (lastc) begin
        col_cnt = 0;
        row_cnt = lastr ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check(res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        fail($sformatf("unexpected normal: col %0d row %0d", got.col, got.row));
        return;
      end
      exp = expected_q.pop_front();
      if (exp !== got)
        fail($sformatf({"normal mismatch: exp col %0d row %0d n (%0d %0d %0d) l%0b d%0b",
                        " got col %0d row %0d n (%0d %0d %0d) l%0b d%0b"},
                       exp.col, exp.row, exp.nx, exp.ny, exp.nz, exp.last_of_run,
                       exp.grid_done, got.col, got.row, got.nx, got.ny, got.nz,
                       got.last_of_run, got.grid_done));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [15:0] height_sample_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [9:0] vertex_col_o;
  logic [15:0] vertex_row_o;
  logic signed [15:0] normal_x_o;
  logic [14:0] normal_y_o;
  logic signed [15:0] normal_z_o;
  logic last_of_run_o;
  logic grid_done_o;

  normal_scoreboard sb = new();
  logic [15:0] sample_q[$];
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned pop_mode = 0;
  int random_items = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  heightmap_vertex_normals uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .height_sample_i(height_sample_i),
    .empty          (empty),
    .pop            (pop),
    .vertex_col_o   (vertex_col_o),
    .vertex_row_o   (vertex_row_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .last_of_run_o  (last_of_run_o),
    .grid_done_o    (grid_done_o)
  );

  always @(posedge clk_i) begin
    bit in_beat, out_beat;
    in_beat = push && !full;
    out_beat = pop && !empty;
    if (in_beat) begin
      sb.note_sample(height_sample_i);
      void'(sample_q.pop_front());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
      end
    end
    if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (!push || in_beat) begin
      push <= sample_q.size() > 0;
      if (sample_q.size() > 0) height_sample_i <= sample_q[0];
    end
    if (out_beat)
      sb.check('{vertex_col_o, vertex_row_o, normal_x_o, normal_y_o, normal_z_o,
                 last_of_run_o, grid_done_o});

    cycle_cnt++;
    if (cycle_cnt % 256 == 0) pop_mode = $urandom_range(0, 2);
    if (pop_mode == 0) begin
      pop <= 1'b1;
    end else if (pop_mode == 1) begin
      pop <= $urandom_range(0, 1);
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(5, 60);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end

    idle_cnt = (in_beat || out_beat || cfg_we_i) ? 0 : idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("heightmap_vertex_normals verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || push || sb.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_grid(int unsigned wreg, int unsigned hreg, int unsigned recip,
                          sample_mode_e mode);
    int unsigned wc, hc, base;
    int v;
    write_reg(CFG_GRID_WIDTH, 24'(wreg));
    write_reg(CFG_GRID_HEIGHT, 24'(hreg));
    write_reg(CFG_HEIGHT_RECIP, 24'(recip));
    wc = (wreg & 11'h7FF) < 2 ? 2 : ((wreg & 11'h7FF) > MAX_W ? MAX_W : (wreg & 11'h7FF));
    hc = hreg < 2 ? 2 : hreg;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < wc * hc; i++) begin
      case (mode)
        SMP_RANDOM: v = $urandom_range(0, 65535);
        SMP_SMOOTH: begin
          v = int'(base) + int'($urandom_range(0, 64)) - 32;
          v = v < 0 ? 0 : (v > 65535 ? 65535 : v);
        end
        SMP_FLAT: v = base;
        SMP_CHECKER: v = (((i % wc) + (i / wc)) & 1) ? 65535 : 0;
        default: v = (i * 4099) & 16'hFFFF;
      endcase
      sample_q.push_back(16'(v));
    end
    wait_idle();
  endtask

  initial begin
    int unsigned wreg, hreg, recip;
    sample_mode_e mode;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_reg(CFG_NONE, 24'hFFFFFF);
    write_reg(CFG_GRID_HEIGHT, 24'hFFFF);
    run_grid(2, 2, 24'hFFFFFF, SMP_CHECKER);
    run_grid(3, 3, 1, SMP_CHECKER);
    run_grid(0, 1, 65536, SMP_FLAT);
    run_grid(3, 2, 24'hFFFFFF, SMP_RAMP);
    run_grid(9, 4, 65536, SMP_SMOOTH);

    while (random_items < 390) begin
      case ($urandom_range(0, 3))
        0: recip = 65536;
        1: recip = $urandom_range(1, 24'hFFFFFF);
        2: recip = $urandom_range(1, 1024);
        default: recip = $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 1;
      endcase
      wreg = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 9);
      hreg = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 7);
      mode = sample_mode_e'($urandom_range(0, 4));
      run_grid(wreg, hreg, recip, mode);
      random_items += (wreg < 2 ? 2 : wreg) * (hreg < 2 ? 2 : hreg);
    end

    if (sb.expected_q.size() != 0) sb.fail("normals still outstanding at end of run");
    if (sb.errors == 0) begin
      $display("heightmap_vertex_normals verification clean");
    end else begin
      $display("heightmap_vertex_normals verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/hvn_pkg.sv
hw/rtl/hvn_fifo.sv
hw/rtl/hvn_front.sv
hw/rtl/hvn_norm.sv
hw/rtl/hvn_back.sv
hw/rtl/heightmap_vertex_normals.sv
sim/tb.sv
